### src/ptts_pkg.sv
package ptts_pkg;

    localparam int LEVELS_DEF      = 8;
    localparam int SLOTS_PER_LEVEL = 2;

    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_CREATE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    // Contents of one task slot.
    typedef struct packed {
        logic        active;
        logic [15:0] period;
        logic [15:0] countdown;
    } slot_t;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic shift_en;
        logic load_en;
        logic tick_en;
    } cell_ctrl_t;

endpackage

### src/ptts_cell.sv
module ptts_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  ptts_pkg::cell_ctrl_t ctrl,
    input  ptts_pkg::slot_t     nb,
    input  ptts_pkg::slot_t     load_data,
    output ptts_pkg::slot_t     q
);
    import ptts_pkg::*;

    logic        active_reg;
    logic        active_next;
    logic [15:0] period_reg;
    logic [15:0] period_next;
    logic [15:0] countdown_reg;
    logic [15:0] countdown_next;

    // The cell fed from the scan head applies the tick update on the way in.
    always_comb
    begin
        active_next    = active_reg;
        period_next    = period_reg;
        countdown_next = countdown_reg;
        if (ctrl.load_en)
        begin
            active_next    = load_data.active;
            period_next    = load_data.period;
            countdown_next = load_data.countdown;
        end
        else if (ctrl.shift_en)
        begin
            active_next = nb.active;
            period_next = nb.period;
            if (ctrl.tick_en && nb.active)
            begin
                if (nb.countdown == 16'd0)
                begin
                    countdown_next = nb.period - 16'd1;
                end
                else
                begin
                    countdown_next = nb.countdown - 16'd1;
                end
            end
            else
            begin
                countdown_next = nb.countdown;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg    <= period_next;
        countdown_reg <= countdown_next;
    end

    assign q = '{active: active_reg, period: period_reg, countdown: countdown_reg};

endmodule

### src/periodic_task_tick_scheduler_core.sv
// Create: one result, registered in the cycle after the input transfer.
// Tick: the slot ring rotates one cell per cycle past the head, unless a fire
// must wait for a stalled output; after NSLOTS shifts a flush state registers
// the final result once the output is free.
// One item is in work at a time; the next tick can transfer once the block is idle.
// Reset clears every active bit and the control state at once; no clearing pass.
module periodic_task_tick_scheduler_core #(
    parameter int LEVELS = ptts_pkg::LEVELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [15:0] period,
    input  logic [7:0]  priority_req,
    input  logic [15:0] first_delay,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        fired,
    output logic [2:0]  fired_level,
    output logic        fired_slot,
    output logic        last
);
    import ptts_pkg::*;

    // The slot table is a ring of cells. At rest, cell i holds slot i (level
    // i/2, slot i%2). A tick shifts the ring toward cell 0 once per cycle while
    // the scan is not stalled; the head (cell 0) is examined, and its updated copy
    // enters the last cell. After NSLOTS shifts the ring is aligned again.
    localparam int NSLOTS = LEVELS * SLOTS_PER_LEVEL;
    localparam int IW     = $clog2(NSLOTS);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    state_t       state_reg, state_next;
    logic [IW-1:0] ptr_reg, ptr_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [IW-1:0] pend_idx_reg, pend_idx_next;

    logic          out_valid_reg, out_valid_next;
    logic [1:0]    status_reg, status_next;
    logic          fired_reg, fired_next;
    logic [2:0]    level_reg, level_next;
    logic          slot_reg, slot_next;
    logic          last_reg, last_next;

    slot_t         cell_q [NSLOTS];
    cell_ctrl_t    cell_ctrl [NSLOTS];
    slot_t         load_data;
    logic [NSLOTS-1:0] act_vec;

    logic          out_free;
    logic          in_xfer;
    logic          head_fire;
    logic          step;
    logic [IW-1:0] wr_idx0;
    logic [IW-1:0] wr_idx1;
    logic          in_range;
    logic          create_ok;
    logic [IW-1:0] wr_idx;
    logic [IW+2:0] pend_ext;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == ST_IDLE) && out_free);
    assign in_xfer  = in_valid && !in_stall;

    // Head of the ring during a scan.
    assign head_fire = cell_q[0].active && (cell_q[0].countdown == 16'd0);
    // A fire with an older fire still pending must push that one out first.
    assign step = (state_reg == ST_SCAN) && !(head_fire && pend_valid_reg && !out_free);

    // Create: the two slots of the requested level sit in fixed cells at rest.
    assign wr_idx0   = IW'({priority_req, 1'b0});
    assign wr_idx1   = wr_idx0 | IW'(1);
    assign in_range  = priority_req < 8'(LEVELS);
    assign create_ok = in_xfer && (kind == KIND_CREATE) && in_range
                       && !(act_vec[wr_idx0] && act_vec[wr_idx1]);
    assign wr_idx    = act_vec[wr_idx0] ? wr_idx1 : wr_idx0;
    assign load_data = '{active: 1'b1, period: period, countdown: first_delay};

    // Slot index of a pending fire, zero extended before the 3-bit level select.
    assign pend_ext = {3'b000, pend_idx_reg};

    genvar gi;
    generate
        for (gi = 0; gi < NSLOTS; gi++)
        begin : g_cell
            assign act_vec[gi]            = cell_q[gi].active;
            assign cell_ctrl[gi].shift_en = step;
            assign cell_ctrl[gi].load_en  = create_ok && (wr_idx == IW'(gi));
            assign cell_ctrl[gi].tick_en  = (gi == NSLOTS - 1);

            ptts_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl[gi]),
                .nb        (cell_q[(gi + 1) % NSLOTS]),
                .load_data (load_data),
                .q         (cell_q[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        fired_next      = fired_reg;
        level_next      = level_reg;
        slot_next       = slot_reg;
        last_next       = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (kind == KIND_CREATE)
                    begin
                        out_valid_next = 1'b1;
                        fired_next     = 1'b0;
                        level_next     = 3'd0;
                        slot_next      = 1'b0;
                        last_next      = 1'b1;
                        if (!in_range)
                        begin
                            status_next = STATUS_RANGE;
                        end
                        else if (create_ok)
                        begin
                            status_next = STATUS_OK;
                        end
                        else
                        begin
                            status_next = STATUS_FULL;
                        end
                    end
                    else
                    begin
                        state_next      = ST_SCAN;
                        ptr_next        = '0;
                        pend_valid_next = 1'b0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (step)
                begin
                    if (head_fire)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            status_next    = STATUS_OK;
                            fired_next     = 1'b1;
                            level_next     = pend_ext[3:1];
                            slot_next      = pend_idx_reg[0];
                            last_next      = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = ptr_reg;
                    end
                    if (ptr_reg == IW'(NSLOTS - 1))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + IW'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    // Final result: the held fire, or a quiet result.
                    out_valid_next = 1'b1;
                    status_next    = STATUS_OK;
                    fired_next     = pend_valid_reg;
                    level_next     = pend_valid_reg ? pend_ext[3:1] : 3'd0;
                    slot_next      = pend_valid_reg ? pend_idx_reg[0] : 1'b0;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ptr_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        status_reg   <= status_next;
        fired_reg    <= fired_next;
        level_reg    <= level_next;
        slot_reg     <= slot_next;
        last_reg     <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign fired       = fired_reg;
    assign fired_level = level_reg;
    assign fired_slot  = slot_reg;
    assign last        = last_reg;

`ifndef NO_ASSERTIONS
    a_create_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && kind == KIND_CREATE) |=> (out_valid && last && !fired))
        else $error("create transfer did not produce a single final result");

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input accepted while a tick scan is in progress");

    a_quiet_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !fired) |-> last)
        else $error("non-fire result without last mark");

    a_fire_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fired) |-> (status == STATUS_OK))
        else $error("fire result with nonzero status");
`endif

endmodule

### tb/periodic_task_tick_scheduler_core_test.sv
`timescale 1ns / 100ps

// The bench runs a short directed table and then about ninety random items.
// A model of the task table predicts every result that the directed table does
// not give by hand, and the bench checks each result as it arrives.
module periodic_task_tick_scheduler_core_test;

    import ptts_pkg::*;

    localparam int NUM_SLOTS   = LEVELS_DEF * SLOTS_PER_LEVEL;
    localparam int RANDOM_JOBS = 90;
    // Input idling and output stalls stop for this many items at the end.
    localparam int SETTLE_JOBS = 15;
    // The long output hold-off starts when this many results have been taken.
    localparam int HOLD_AT     = 30;
    localparam int HOLD_LEN    = 250;
    // The wait at the end is longer than a tick scan, so it is enough for any
    // late result to show up.
    localparam int DRAIN_WAIT  = 40;
    // The slowest correct run is about 110 items. Each item can take an idle
    // gap, a scan and sixteen results with a stall burst on each. The limit
    // leaves room for that, and the hold-off comes on top of that.
    localparam int CYCLE_LIMIT = 200000;

    // One input item as the sender drives it.
    typedef struct packed {
        logic        kind;
        logic [15:0] period;
        logic [7:0]  prio;
        logic [15:0] delay;
    } job_t;

    // One result item in the field order of the output ports.
    typedef struct packed {
        status_t     status;
        logic        fired;
        logic [2:0]  level;
        logic        slot;
        logic        last;
    } report_t;

    // A row of the directed table. When the typed flag is set, the row's single
    // result is written out by hand. Otherwise the model predicts the result.
    typedef struct packed {
        job_t    job;
        bit      typed;
        status_t want_status;
    } row_t;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic        kind         = KIND_TICK;
    logic [15:0] period       = '0;
    logic [7:0]  priority_req = '0;
    logic [15:0] first_delay  = '0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [1:0]  status;
    logic        fired;
    logic [2:0]  fired_level;
    logic        fired_slot;
    logic        last;

    // This is the bench's own copy of the task table. Period and countdown are
    // read only while a slot is active, so their reset contents do not matter.
    bit          task_on     [NUM_SLOTS];
    logic [15:0] task_period [NUM_SLOTS];
    logic [15:0] task_count  [NUM_SLOTS];

    report_t     awaited_reports[$];
    row_t        plan[$];
    int          faults        = 0;
    int          cycles        = 0;
    int          reports_taken = 0;
    bit          held          = 1'b0;
    bit          settle        = 1'b0;

    periodic_task_tick_scheduler_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .period       (period),
        .priority_req (priority_req),
        .first_delay  (first_delay),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .fired        (fired),
        .fired_level  (fired_level),
        .fired_slot   (fired_slot),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    // The watchdog ends a run that hangs. A correct run never gets near the limit.
    initial
    begin : watchdog
        wait (cycles >= CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    function automatic report_t report_of(input status_t st, input logic f,
                                          input logic [2:0] lv, input logic sl,
                                          input logic lst);
        report_t r;
        r.status = st;
        r.fired  = f;
        r.level  = lv;
        r.slot   = sl;
        r.last   = lst;
        return r;
    endfunction

    // This applies one accepted item to the task table. When post is set, it
    // also queues the results the item should produce. A create places the task
    // in the first free slot of its level. A tick scans the table in level
    // order and then slot order. It reloads every slot that fires and counts
    // down every other active slot.
    function automatic void advance_task_table(input job_t j, input bit post);
        report_t r;
        report_t prev;
        bit      have_prev;
        bit      placed;
        int      idx;
        int      s;
        have_prev = 1'b0;
        placed    = 1'b0;
        if (j.kind == KIND_CREATE)
        begin
            if (j.prio >= LEVELS_DEF)
            begin
                r = report_of(STATUS_RANGE, 1'b0, 3'd0, 1'b0, 1'b1);
            end
            else
            begin
                r = report_of(STATUS_FULL, 1'b0, 3'd0, 1'b0, 1'b1);
                for (s = 0; s < SLOTS_PER_LEVEL; s++)
                begin
                    idx = j.prio * SLOTS_PER_LEVEL + s;
                    if (!placed && !task_on[idx])
                    begin
                        placed           = 1'b1;
                        task_on[idx]     = 1'b1;
                        task_period[idx] = j.period;
                        task_count[idx]  = j.delay;
                        r = report_of(STATUS_OK, 1'b0, 3'd0, 1'b0, 1'b1);
                    end
                end
            end
            if (post)
                awaited_reports.push_back(r);
        end
        else
        begin
            for (idx = 0; idx < NUM_SLOTS; idx++)
            begin
                if (task_on[idx])
                begin
                    if (task_count[idx] == 16'd0)
                    begin
                        // Subtracting one from a zero period wraps to 65535.
                        task_count[idx] = task_period[idx] - 16'd1;
                        if (post && have_prev)
                            awaited_reports.push_back(prev);
                        prev = report_of(STATUS_OK, 1'b1, 3'(idx / SLOTS_PER_LEVEL),
                                         1'(idx % SLOTS_PER_LEVEL), 1'b0);
                        have_prev = 1'b1;
                    end
                    else
                    begin
                        task_count[idx] = task_count[idx] - 16'd1;
                    end
                end
            end
            if (post)
            begin
                if (have_prev)
                begin
                    // Only the final firing of a tick carries the last mark.
                    prev.last = 1'b1;
                    awaited_reports.push_back(prev);
                end
                else
                begin
                    awaited_reports.push_back(report_of(STATUS_OK, 1'b0, 3'd0, 1'b0, 1'b1));
                end
            end
        end
    endfunction

    function automatic void add_row(input logic k, input logic [15:0] per,
                                    input logic [7:0] pr, input logic [15:0] dly,
                                    input bit typed, input status_t st);
        row_t r;
        r.job.kind    = k;
        r.job.period  = per;
        r.job.prio    = pr;
        r.job.delay   = dly;
        r.typed       = typed;
        r.want_status = st;
        plan.push_back(r);
    endfunction

    // About a third of the random items are creates. Most of them use short
    // periods and delays at in-range levels, so that tasks fire again and again
    // and the table fills up. The rest use full-range values, which bring in
    // out-of-range levels and tasks that hardly ever fire. Ticks carry random
    // values in the unused fields, so every input bit sees both values.
    function automatic job_t random_job();
        job_t j;
        j.period = 16'($urandom);
        j.prio   = 8'($urandom);
        j.delay  = 16'($urandom);
        if ($urandom_range(0, 99) < 32)
        begin
            j.kind = KIND_CREATE;
            if ($urandom_range(0, 9) != 0)
                j.period = 16'($urandom_range(0, 6));
            if ($urandom_range(0, 5) != 0)
                j.prio = 8'($urandom_range(0, LEVELS_DEF - 1));
            if ($urandom_range(0, 9) != 0)
                j.delay = 16'($urandom_range(0, 5));
        end
        else
        begin
            j.kind = KIND_TICK;
        end
        return j;
    endfunction

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            faults++;
            $display("%0t: %s expected %0d, actual %0d", $realtime, what, want, got);
        end
    endfunction

    // The sender may idle for a random burst before it offers the item. It then
    // holds the item on the inputs until a transfer happens. All assignments
    // are made at a rising edge, and each signal gets at most one per edge.
    task automatic offer_job(input job_t j, input bit may_idle);
        int gap;
        if (may_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= j.kind;
        period       <= j.period;
        priority_req <= j.prio;
        first_delay  <= j.delay;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // The receiver takes a result at every edge where out_valid is high and
    // out_stall is low. It then decides out_stall for the next cycle. Random
    // stall bursts happen only in the first two thirds of each repeating window,
    // so there are also clean stretches. Once, the receiver holds off for a long
    // stretch. The sender keeps offering items during it, so the block backs up
    // and stalls its input.
    initial
    begin : receiver
        int      stall_left;
        report_t got;
        report_t want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got = report_of(status_t'(status), fired, fired_level, fired_slot, last);
                reports_taken++;
                if (awaited_reports.size() == 0)
                begin
                    faults++;
                    $display("%0t: result with none awaited: expected nothing, actual status %0d fired %0d level %0d slot %0d last %0d",
                             $realtime, got.status, got.fired, got.level, got.slot,
                             got.last);
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("fired", want.fired, got.fired);
                    check_field("fired_level", want.level, got.level);
                    check_field("fired_slot", want.slot, got.slot);
                    check_field("last", want.last, got.last);
                end
            end
            if (!held && reports_taken >= HOLD_AT)
            begin
                held       = 1'b1;
                stall_left = HOLD_LEN;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (!settle && (cycles % 300) < 200 && $urandom_range(0, 5) == 0)
            begin
                out_stall  <= 1'b1;
                stall_left = $urandom_range(1, 17) - 1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : stimulus
        job_t j;
        int   k;

        // Reset is asserted once, from time zero, and released at a clock edge.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The directed table. A tick right after reset finds nothing to fire.
        // Out-of-range levels cover the extremes of the level field. A task with
        // zero period and zero delay fires on the first tick and then wraps to
        // the longest countdown. A full level is tried at both ends of the
        // level range. Full-scale period and delay sit in the top level.
        add_row(KIND_TICK,   16'd0,     8'd0,   16'd0,     1'b1, STATUS_OK);
        add_row(KIND_CREATE, 16'd5,     8'd255, 16'd0,     1'b1, STATUS_RANGE);
        add_row(KIND_CREATE, 16'd2,     8'd8,   16'd1,     1'b1, STATUS_RANGE);
        add_row(KIND_CREATE, 16'd0,     8'd0,   16'd0,     1'b1, STATUS_OK);
        add_row(KIND_CREATE, 16'd3,     8'd0,   16'd1,     1'b1, STATUS_OK);
        add_row(KIND_CREATE, 16'd4,     8'd0,   16'd0,     1'b1, STATUS_FULL);
        add_row(KIND_CREATE, 16'hFFFF,  8'd7,   16'hFFFF,  1'b1, STATUS_OK);
        add_row(KIND_CREATE, 16'd1,     8'd7,   16'd0,     1'b1, STATUS_OK);
        add_row(KIND_CREATE, 16'd9,     8'd7,   16'd2,     1'b1, STATUS_FULL);
        add_row(KIND_TICK,   16'd0,     8'd0,   16'd0,     1'b0, STATUS_OK);
        add_row(KIND_TICK,   16'hFFFF,  8'hFF,  16'hFFFF,  1'b0, STATUS_OK);
        add_row(KIND_CREATE, 16'd2,     8'd3,   16'd2,     1'b1, STATUS_OK);
        add_row(KIND_CREATE, 16'd1,     8'd3,   16'd0,     1'b1, STATUS_OK);
        add_row(KIND_CREATE, 16'd4,     8'd4,   16'd3,     1'b1, STATUS_OK);
        add_row(KIND_TICK,   16'hAAAA,  8'h55,  16'h5555,  1'b0, STATUS_OK);
        add_row(KIND_TICK,   16'h5555,  8'hAA,  16'hAAAA,  1'b0, STATUS_OK);
        add_row(KIND_TICK,   16'd0,     8'd0,   16'd0,     1'b0, STATUS_OK);
        add_row(KIND_TICK,   16'd0,     8'd0,   16'd0,     1'b0, STATUS_OK);
        add_row(KIND_TICK,   16'd0,     8'd0,   16'd0,     1'b0, STATUS_OK);
        add_row(KIND_TICK,   16'd0,     8'd0,   16'd0,     1'b0, STATUS_OK);

        foreach (plan[i])
        begin
            offer_job(plan[i].job, 1'b1);
            // The table row gives the expected result, but the model still has
            // to track the state change the item makes.
            advance_task_table(plan[i].job, !plan[i].typed);
            if (plan[i].typed)
                awaited_reports.push_back(report_of(plan[i].want_status, 1'b0, 3'd0,
                                                    1'b0, 1'b1));
        end

        for (k = 0; k < RANDOM_JOBS; k++)
        begin
            // The last stretch runs with no idling and no stalls.
            settle = (k >= RANDOM_JOBS - SETTLE_JOBS);
            j = random_job();
            offer_job(j, !settle && (k % 30) < 20);
            advance_task_table(j, 1'b1);
        end
        in_valid <= 1'b0;

        // Wait for every awaited result. Then give any extra result time to
        // appear before deciding the outcome.
        while (awaited_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (faults == 0 && awaited_reports.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
